>>> hdl/grt_pkg.sv
// Package for the grid ray traversal block.
// Holds grid and distance sizes plus the controller/datapath command and status structs.
// No dependencies.
package grt_pkg;

  localparam int GRID_DIM = 64;
  localparam int COORD_W  = 6;
  localparam int DIST_W   = 32;
  localparam int CELLS    = GRID_DIM * GRID_DIM;
  localparam int CELL_AW  = $clog2(CELLS);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CAST  = 1'b1;

  typedef struct packed {
    logic clear;
    logic write;
    logic load;
    logic step;
    logic hit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic start_in;
    logic exit_map;
    logic wall;
  } stat_t;

endpackage

>>> hdl/grid_ray_traversal.sv
// Top level of the grid ray traversal block: controller plus datapath.
// Depends on grt_pkg, grt_ctrl, grt_datapath.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// req_type selects a map write (cell_x, cell_y, wall_bit) or a ray cast
// (start cell, side distances, deltas, step signs). A write takes the accept
// cycle only and gives no result; busy stays low.
// A cast walks the 64x64 wall map one cell per step, at most 127 steps.
// A step that stays in the grid picks the axis, adds its delta and addresses
// the map in S_STEP, then checks the registered map read in S_CHECK. A step
// that leaves the grid ends the walk from S_STEP. The result is shown for
// one cycle with done high. busy drops after the done cycle.
// The receiver cannot stall: a result is shown once and must be taken.
// After reset the map is cleared one cell per cycle, all 4096 cells, with
// busy high; no request is taken until that sweep finishes.
module grid_ray_traversal (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              req_type,
  input  logic [grt_pkg::COORD_W-1:0]       cell_x,
  input  logic [grt_pkg::COORD_W-1:0]       cell_y,
  input  logic                              wall_bit,
  input  logic [grt_pkg::DIST_W-1:0]        start_side_x,
  input  logic [grt_pkg::DIST_W-1:0]        start_side_y,
  input  logic [grt_pkg::DIST_W-1:0]        delta_x,
  input  logic [grt_pkg::DIST_W-1:0]        delta_y,
  input  logic signed [1:0]                 dir_step_x,
  input  logic signed [1:0]                 dir_step_y,
  output logic                              done,
  output logic                              status,
  output logic [grt_pkg::COORD_W-1:0]       hit_x,
  output logic [grt_pkg::COORD_W-1:0]       hit_y,
  output logic                              hit_side,
  output logic [grt_pkg::DIST_W-1:0]        end_side_x,
  output logic [grt_pkg::DIST_W-1:0]        end_side_y
);

  grt_pkg::cmd_t  cmd;
  grt_pkg::stat_t st;

  grt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .st       (st),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  grt_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .wall_bit     (wall_bit),
    .start_side_x (start_side_x),
    .start_side_y (start_side_y),
    .delta_x      (delta_x),
    .delta_y      (delta_y),
    .dir_step_x   (dir_step_x),
    .dir_step_y   (dir_step_y),
    .status       (status),
    .hit_x        (hit_x),
    .hit_y        (hit_y),
    .hit_side     (hit_side),
    .end_side_x   (end_side_x),
    .end_side_y   (end_side_y)
  );

endmodule

>>> hdl/grt_ctrl.sv
// Controller state machine for the grid ray traversal block.
// Depends on grt_pkg (cmd_t, stat_t, request codes).
module grt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           req_type,
  input  grt_pkg::stat_t st,
  output grt_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_STEP  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (req_type == grt_pkg::REQ_WRITE) begin
            cmd.write = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = st.start_in ? S_STEP : S_DONE;
          end
        end
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = st.exit_map ? S_DONE : S_CHECK;
      end
      S_CHECK: begin
        if (st.wall) begin
          cmd.hit    = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_STEP;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  a_exit_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && st.exit_map) |=> done)
    else $error("exit step did not finish the cast");

  a_open_continue: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && !st.wall) |=> (state == S_STEP))
    else $error("open cell did not continue the walk");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_STEP || $past(state) == S_CHECK || $past(state) == S_IDLE))
    else $error("result strobe without a cast");

endmodule

>>> hdl/grt_datapath.sv
// Datapath for the grid ray traversal block: wall map, walk registers, result registers.
// Depends on grt_pkg (sizes, cmd_t, stat_t).
module grt_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  grt_pkg::cmd_t                     cmd,
  output grt_pkg::stat_t                    st,
  input  logic [grt_pkg::COORD_W-1:0]       cell_x,
  input  logic [grt_pkg::COORD_W-1:0]       cell_y,
  input  logic                              wall_bit,
  input  logic [grt_pkg::DIST_W-1:0]        start_side_x,
  input  logic [grt_pkg::DIST_W-1:0]        start_side_y,
  input  logic [grt_pkg::DIST_W-1:0]        delta_x,
  input  logic [grt_pkg::DIST_W-1:0]        delta_y,
  input  logic signed [1:0]                 dir_step_x,
  input  logic signed [1:0]                 dir_step_y,
  output logic                              status,
  output logic [grt_pkg::COORD_W-1:0]       hit_x,
  output logic [grt_pkg::COORD_W-1:0]       hit_y,
  output logic                              hit_side,
  output logic [grt_pkg::DIST_W-1:0]        end_side_x,
  output logic [grt_pkg::DIST_W-1:0]        end_side_y
);

  logic                         wall_map [grt_pkg::CELLS];
  logic [grt_pkg::CELL_AW-1:0]  clr_cnt;
  logic                         rdata;

  logic [grt_pkg::COORD_W-1:0]  x;
  logic [grt_pkg::COORD_W-1:0]  y;
  logic [grt_pkg::DIST_W-1:0]   sx;
  logic [grt_pkg::DIST_W-1:0]   sy;
  logic [grt_pkg::DIST_W-1:0]   dx;
  logic [grt_pkg::DIST_W-1:0]   dy;
  logic                         neg_x;
  logic                         neg_y;
  logic                         side;
  logic                         stat;

  logic                         take_x;
  logic [grt_pkg::DIST_W:0]     sum_x;
  logic [grt_pkg::DIST_W:0]     sum_y;
  logic [grt_pkg::DIST_W-1:0]   sx_next;
  logic [grt_pkg::DIST_W-1:0]   sy_next;
  logic [grt_pkg::COORD_W-1:0]  x_next;
  logic [grt_pkg::COORD_W-1:0]  y_next;
  logic                         x_out;
  logic                         y_out;
  logic [grt_pkg::CELL_AW-1:0]  rd_addr;
  logic [grt_pkg::CELL_AW-1:0]  wr_addr;
  logic                         in_ok;

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign st.clear_last = (32'(clr_cnt) == grt_pkg::CELLS - 1);

  assign in_ok   = (32'(cell_x) < grt_pkg::GRID_DIM) && (32'(cell_y) < grt_pkg::GRID_DIM);
  assign wr_addr = grt_pkg::CELL_AW'(32'(cell_x) * grt_pkg::GRID_DIM + 32'(cell_y));
  assign st.start_in = in_ok;

  // step arithmetic
  assign take_x  = (sx < sy);
  assign sum_x   = {1'b0, sx} + {1'b0, dx};
  assign sum_y   = {1'b0, sy} + {1'b0, dy};
  assign sx_next = sum_x[grt_pkg::DIST_W] ? '1 : sum_x[grt_pkg::DIST_W-1:0];
  assign sy_next = sum_y[grt_pkg::DIST_W] ? '1 : sum_y[grt_pkg::DIST_W-1:0];

  assign x_out  = neg_x ? (x == '0) : (32'(x) == grt_pkg::GRID_DIM - 1);
  assign y_out  = neg_y ? (y == '0) : (32'(y) == grt_pkg::GRID_DIM - 1);
  assign x_next = take_x ? (neg_x ? x - 1'b1 : x + 1'b1) : x;
  assign y_next = take_x ? y : (neg_y ? y - 1'b1 : y + 1'b1);
  assign st.exit_map = take_x ? x_out : y_out;
  assign rd_addr = grt_pkg::CELL_AW'(32'(x_next) * grt_pkg::GRID_DIM + 32'(y_next));

  // wall map
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      wall_map[clr_cnt] <= 1'b0;
    end else if (cmd.write && in_ok) begin
      wall_map[wr_addr] <= wall_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rdata <= wall_map[rd_addr];
    end
  end

  assign st.wall = rdata;

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x     <= cell_x;
      y     <= cell_y;
      sx    <= start_side_x;
      sy    <= start_side_y;
      dx    <= delta_x;
      dy    <= delta_y;
      neg_x <= dir_step_x[1];
      neg_y <= dir_step_y[1];
      side  <= 1'b0;
      stat  <= 1'b1;
    end else if (cmd.step) begin
      side <= ~take_x;
      if (take_x) begin
        sx <= sx_next;
      end else begin
        sy <= sy_next;
      end
      if (!st.exit_map) begin
        x <= x_next;
        y <= y_next;
      end
    end else if (cmd.hit) begin
      stat <= 1'b0;
    end
  end

  assign status     = stat;
  assign hit_x      = x;
  assign hit_y      = y;
  assign hit_side   = side;
  assign end_side_x = sx;
  assign end_side_y = sy;

endmodule
